// ===== sv/gebi_pkg.sv =====
// Shared types and constants for the graph edge unranking block.
`default_nettype none
package gebi_pkg;

    // Default vertex number width.
    localparam int VERTEX_BITS_DEF = 16;
    // Fixed field widths of the ports.
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 31;
    localparam int VERT_W = 16;

    // Graph kinds.
    typedef enum logic [1:0] {
        KIND_COMPLETE = 2'd0,
        KIND_CYCLE    = 2'd1,
        KIND_PATH     = 2'd2,
        KIND_STAR     = 2'd3
    } kind_t;

    // Request payload carried along the cell chain.
    typedef struct packed {
        kind_t                kind;
        logic                 bad;
        logic [IDX_W-1:0]     k;
        logic [VERT_W-1:0]    a;
        logic [VERT_W-1:0]    b;
    } item_t;

endpackage
`default_nettype wire

// ===== sv/gebi_front.sv =====
// Entry stage: edge count check and direct decode of cycle, path and star.
`default_nettype none
module gebi_front import gebi_pkg::*; #(
    parameter int NW = VERTEX_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic [NW-1:0]     n,
    input  wire logic              in_valid,
    input  wire logic [1:0]        in_func,
    input  wire logic [IDX_W-1:0]  in_k,
    output logic                   out_valid,
    output item_t                  out_item,
    output logic [NW-1:0]          out_r,
    output logic [IDX_W-1:0]       out_off
);

    logic              valid_reg;
    item_t             item_reg, item_next;
    logic [2*NW-1:0]   pair_prod;
    logic [63:0]       count;
    logic [63:0]       k64;
    logic [63:0]       n64;
    logic [VERT_W-1:0] k_p1;
    logic [VERT_W-1:0] k_p2;

    // Edge count per kind, range check and direct endpoints.
    always_comb begin
        pair_prod = (2*NW)'(n) * (2*NW)'(n - NW'(1));
        k64       = 64'(in_k);
        n64       = 64'(n);
        k_p1      = in_k[VERT_W-1:0] + VERT_W'(1);
        k_p2      = in_k[VERT_W-1:0] + VERT_W'(2);
        item_next.kind = kind_t'(in_func);
        item_next.k    = in_k;
        item_next.a    = '0;
        item_next.b    = '0;
        count          = '0;
        unique case (kind_t'(in_func))
            KIND_COMPLETE: begin
                if (n64 >= 64'd2) begin
                    count = 64'(pair_prod >> 1);
                end
            end
            KIND_CYCLE: begin
                if (n64 >= 64'd3) begin
                    count = n64;
                end else if (n64 == 64'd2) begin
                    count = 64'd1;
                end
                if (k64 + 64'd1 < n64) begin
                    item_next.a = k_p1;
                    item_next.b = k_p2;
                end else begin
                    item_next.a = VERT_W'(n);
                    item_next.b = VERT_W'(1);
                end
            end
            KIND_PATH: begin
                if (n64 >= 64'd1) begin
                    count = n64 - 64'd1;
                end
                item_next.a = k_p1;
                item_next.b = k_p2;
            end
            KIND_STAR: begin
                if (n64 >= 64'd1) begin
                    count = n64 - 64'd1;
                end
                item_next.a = VERT_W'(1);
                item_next.b = k_p2;
            end
            default: begin
                count = '0;
            end
        endcase
        item_next.bad = (k64 >= count);
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_r     = '0;
    assign out_off   = '0;

endmodule
`default_nettype wire

// ===== sv/gebi_cell.sv =====
// One row search cell: decides one bit of the complete graph row number.
`default_nettype none
module gebi_cell import gebi_pkg::*; #(
    parameter int NW  = VERTEX_BITS_DEF,
    parameter int BIT = 0
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic [NW-1:0]     n,
    input  wire logic              in_valid,
    input  wire item_t             in_item,
    input  wire logic [NW-1:0]     in_r,
    input  wire logic [IDX_W-1:0]  in_off,
    output logic                   out_valid,
    output item_t                  out_item,
    output logic [NW-1:0]          out_r,
    output logic [IDX_W-1:0]       out_off
);

    logic              valid_reg;
    item_t             item_reg;
    logic [NW-1:0]     r_reg, r_next;
    logic [IDX_W-1:0]  off_reg, off_next;
    logic [NW-1:0]     cand;
    logic [NW:0]       span;
    logic [2*NW:0]     prod;
    logic [2*NW-1:0]   cand_off;
    logic              take;

    // Try setting this cell's bit: keep it if the row exists and starts at or before k.
    always_comb begin
        cand     = in_r | (NW'(1) << BIT);
        span     = {n, 1'b0} - {1'b0, cand};
        prod     = (2*NW+1)'(cand - NW'(1)) * (2*NW+1)'(span);
        cand_off = prod[2*NW:1];
        take     = (cand < n) && (64'(cand_off) <= 64'(in_item.k));
        r_next   = take ? cand : in_r;
        off_next = take ? cand_off[IDX_W-1:0] : in_off;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg <= in_item;
            r_reg    <= r_next;
            off_reg  <= off_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign out_r     = r_reg;
    assign out_off   = off_reg;

endmodule
`default_nettype wire

// ===== sv/graph_edge_by_index.sv =====
// Edge unranking: returns the endpoints of an indexed edge of a standard graph.
// Usage: write the vertex count n through cfg_wr_en / cfg_wr_data while idle;
// it resets to 0, where every index reports out of range.
// A request on the s_ channel carries the graph kind (complete, cycle, path,
// star) and a zero-based edge index. Each request gives exactly one response
// on the m_ channel with both endpoints and an out-of-range flag.
// The datapath is an entry stage, a chain of VERTEX_BITS search cells and an
// output register. Each cell fixes one bit of the complete graph row number
// with one row offset multiply and compare. m_valid rises once the request
// has passed the entry stage, every search cell and the output register.
// Unless the chain is held, a request is taken every cycle: one request per cycle.
// When m_ready is low with a response held, the whole chain holds and
// s_ready drops until the response is taken; nothing is lost or repeated.
// Reset is synchronous and active low; it empties the chain and the output.
`default_nettype none
module graph_edge_by_index import gebi_pkg::*; #(
    parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_W-1:0]  cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_func,
    input  wire logic [IDX_W-1:0]  s_edge_index,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [VERT_W-1:0]      m_first_vertex,
    output logic [VERT_W-1:0]      m_second_vertex,
    output logic                   m_out_of_range
);

    localparam int NW = VERTEX_BITS;

    logic [NW-1:0]     n_reg;
    logic              adv;
    logic              st_valid [NW+1];
    item_t             st_item  [NW+1];
    logic [NW-1:0]     st_r     [NW+1];
    logic [IDX_W-1:0]  st_off   [NW+1];
    logic              m_valid_reg;
    logic [VERT_W-1:0] first_reg, first_next;
    logic [VERT_W-1:0] second_reg, second_next;
    logic              oor_reg;
    item_t             last;
    logic [IDX_W-1:0]  rem;

    // Vertex count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= '0;
        end else if (cfg_wr_en) begin
            n_reg <= NW'(cfg_wr_data);
        end
    end

    // The chain moves whenever the output register is free or being emptied.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    gebi_front #(.NW(NW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .n         (n_reg),
        .in_valid  (s_valid),
        .in_func   (s_func),
        .in_k      (s_edge_index),
        .out_valid (st_valid[0]),
        .out_item  (st_item[0]),
        .out_r     (st_r[0]),
        .out_off   (st_off[0])
    );

    // Search cells, most significant row bit first.
    for (genvar i = 0; i < NW; i++) begin : g_cell
        gebi_cell #(.NW(NW), .BIT(NW - 1 - i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .n         (n_reg),
            .in_valid  (st_valid[i]),
            .in_item   (st_item[i]),
            .in_r      (st_r[i]),
            .in_off    (st_off[i]),
            .out_valid (st_valid[i+1]),
            .out_item  (st_item[i+1]),
            .out_r     (st_r[i+1]),
            .out_off   (st_off[i+1])
        );
    end

    // Final endpoints: complete graph column comes from the offset within the row.
    always_comb begin
        last = st_item[NW];
        rem  = last.k - st_off[NW];
        if (last.bad) begin
            first_next  = '0;
            second_next = '0;
        end else if (last.kind == KIND_COMPLETE) begin
            first_next  = VERT_W'(st_r[NW]);
            second_next = VERT_W'(st_r[NW]) + VERT_W'(1) + rem[VERT_W-1:0];
        end else begin
            first_next  = last.a;
            second_next = last.b;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= st_valid[NW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && st_valid[NW]) begin
            first_reg  <= first_next;
            second_reg <= second_next;
            oor_reg    <= last.bad;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_first_vertex  = first_reg;
    assign m_second_vertex = second_reg;
    assign m_out_of_range  = oor_reg;

endmodule
`default_nettype wire
